FILE: design/dlac_pkg.sv
// Shared types and codes for the deadlock avoidance cycle check block.
// No dependencies.
`timescale 1ns / 1ps
package dlac_pkg;

  localparam logic [1:0] ACT_CLAIM   = 2'd0;
  localparam logic [1:0] ACT_HOLD    = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;

  localparam logic [1:0] ST_SETUP_DONE = 2'd0;
  localparam logic [1:0] ST_GRANTED    = 2'd1;
  localparam logic [1:0] ST_REFUSED    = 2'd2;

  localparam logic CFG_PROC_COUNT = 1'b0;
  localparam logic CFG_RES_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;    // take the item at the input ports
    logic step;    // evaluate one process of the scan
    logic finish;  // scan converged, commit and set status
  } dlac_cmd_t;

  typedef struct packed {
    logic check_req; // item at the ports is an in-use request
    logic last;      // scan is at the last process in use
    logic changed;   // this pass removed some process so far
  } dlac_stat_t;

endpackage

FILE: design/deadlock_avoidance_cycle_check.sv
// Setup items go straight to a result; a request runs passes of the elimination scan,
//   one process per cycle over process_count processes, up to process_count + 1 passes.
// Intake: one item at a time; next item taken the cycle after the result is taken.
// Reset (rst_n, synchronous): graph cleared, counts set to 16 clamped to the parameters.
// Top level; depends on dlac_pkg, dlac_ctrl, dlac_datapath.
`timescale 1ns / 1ps
module deadlock_avoidance_cycle_check
  import dlac_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [3:0] in_process_id,
  input  logic [3:0] in_resource_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status
);

  // A request is checked against the graph with the grant overlaid, not
  // written in: processes with no edge to a live process are peeled off
  // pass after pass; whatever survives a quiet pass lies on or waits on a cycle.
  // The graph is only written once the grant proves safe, so a refusal
  // needs no restore.
  dlac_cmd_t  cmd;
  dlac_stat_t stat;

  dlac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dlac_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_action),
    .in_process_id  (in_process_id),
    .in_resource_id (in_resource_id),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status)
  );

  // A pending result blocks intake.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("intake open with result pending");

  // An accepted item closes intake next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("intake open after accept");

  // Status is always a defined code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("undefined status");

endmodule

FILE: design/dlac_ctrl.sv
// Controller state machine for the cycle check.
// Depends on dlac_pkg.
`timescale 1ns / 1ps
module dlac_ctrl
  import dlac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dlac_stat_t stat,
  output dlac_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.check_req ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.last && !stat.changed) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/dlac_datapath.sv
// Graph state, counts and the process elimination scan.
// Depends on dlac_pkg.
`timescale 1ns / 1ps
module dlac_datapath
  import dlac_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic [1:0] in_action,
  input  logic [3:0] in_process_id,
  input  logic [3:0] in_resource_id,
  input  dlac_cmd_t  cmd,
  output dlac_stat_t stat,
  output logic [1:0] out_status
);

  localparam int OW  = $clog2(MAX_PROCESSES);
  localparam int RW  = $clog2(MAX_RESOURCES);
  localparam int PCW = $clog2(MAX_PROCESSES + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);

  logic [MAX_RESOURCES-1:0] claim_r [MAX_PROCESSES];
  logic [MAX_RESOURCES-1:0] held_r;
  logic [OW-1:0]            owner_r [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] alive_r;
  logic [PCW-1:0]           pc_r;
  logic [RCW-1:0]           rc_r;
  logic [OW-1:0]            tp_r, scan_r;
  logic [RW-1:0]            tr_r;
  logic                     changed_r;
  logic [1:0]               status_r;

  logic                     in_use;
  logic [OW-1:0]            in_p;
  logic [RW-1:0]            in_r;
  logic [MAX_RESOURCES-1:0] row, edges;
  logic                     alive_new, chg_now, cycle;

  assign in_p   = OW'(in_process_id);
  assign in_r   = RW'(in_resource_id);
  assign in_use = (int'(in_process_id) < int'(pc_r)) && (int'(in_resource_id) < int'(rc_r));

  // Edges of the scanned process, with the tentative grant overlaid.
  always_comb begin
    row = claim_r[scan_r];
    if (scan_r == tp_r) row[tr_r] = 1'b0;
    for (int r = 0; r < MAX_RESOURCES; r++) begin
      if (RW'(r) == tr_r)
        edges[r] = row[r] && (r < int'(rc_r)) && alive_r[tp_r];
      else
        edges[r] = row[r] && (r < int'(rc_r)) && held_r[r] && alive_r[owner_r[r]];
    end
  end

  assign alive_new = alive_r[scan_r] && (|edges);
  assign chg_now   = alive_r[scan_r] && !alive_new;
  assign cycle     = |alive_r;

  assign stat.check_req = (in_action == ACT_REQUEST) && in_use;
  assign stat.last      = (PCW'(scan_r) == pc_r - PCW'(1));
  assign stat.changed   = changed_r || chg_now;
  assign out_status     = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PCW'(MAX_PROCESSES < 16 ? MAX_PROCESSES : 16);
      rc_r   <= RCW'(MAX_RESOURCES < 16 ? MAX_RESOURCES : 16);
      held_r <= '0;
      for (int i = 0; i < MAX_PROCESSES; i++) claim_r[i] <= '0;
      for (int i = 0; i < MAX_RESOURCES; i++) owner_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PROC_COUNT)
          pc_r <= (cfg_wdata == 5'd0) ? PCW'(1) :
                  (int'(cfg_wdata) > MAX_PROCESSES) ? PCW'(MAX_PROCESSES) : PCW'(cfg_wdata);
        else
          rc_r <= (cfg_wdata == 5'd0) ? RCW'(1) :
                  (int'(cfg_wdata) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(cfg_wdata);
      end
      if (cmd.load && in_use) begin
        if (in_action == ACT_CLAIM) claim_r[in_p][in_r] <= 1'b1;
        if (in_action == ACT_HOLD) begin
          held_r[in_r]  <= 1'b1;
          owner_r[in_r] <= in_p;
        end
      end
      if (cmd.finish && !cycle) begin
        claim_r[tp_r][tr_r] <= 1'b0;
        held_r[tr_r]        <= 1'b1;
        owner_r[tr_r]       <= tp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tp_r      <= in_p;
      tr_r      <= in_r;
      scan_r    <= '0;
      changed_r <= 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) alive_r[i] <= (i < int'(pc_r));
      status_r  <= (in_action == ACT_REQUEST) ? ST_REFUSED : ST_SETUP_DONE;
    end else if (cmd.step) begin
      alive_r[scan_r] <= alive_new;
      if (stat.last) begin
        scan_r    <= '0;
        changed_r <= 1'b0;
      end else begin
        scan_r    <= scan_r + OW'(1);
        changed_r <= stat.changed;
      end
      if (cmd.finish) status_r <= cycle ? ST_REFUSED : ST_GRANTED;
    end
  end

endmodule
